### rtl/core/modular_exponentiation_macros.svh
// -----------------------------------------------------------------------------
// modular_exponentiation_macros.svh
// Assertion shorthands for the modular exponentiation core. They expect
// clk and rst_n in scope.
// -----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Same-cycle implication.
`define MEXP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MEXP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/mexp_pkg.sv
// -----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, types and state encoding of the modular exponentiation core.
// -----------------------------------------------------------------------------
package mexp_pkg;

    // Port fields are fixed at 64 bits; arithmetic uses the low DATA_WIDTH bits.
    localparam int FIELD_WIDTH = 64;
    localparam int DATA_WIDTH  = 64;
    localparam int CNT_WIDTH   = $clog2(DATA_WIDTH);

    typedef logic [FIELD_WIDTH-1:0] field_t;
    typedef logic [DATA_WIDTH-1:0]  word_t;
    typedef logic [CNT_WIDTH-1:0]   cnt_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_NEXT,
        ST_MUL_ACC,
        ST_MUL_PW,
        ST_FINISH
    } state_t;

endpackage

### rtl/core/mexp_req_if.sv
// -----------------------------------------------------------------------------
// mexp_req_if
// Request channel: base, exponent and modulus with valid/ready.
// -----------------------------------------------------------------------------
interface mexp_req_if import mexp_pkg::*;;
    logic   valid;
    logic   ready;
    field_t base;
    field_t exponent;
    field_t modulus;

    modport source (output valid, output base, output exponent, output modulus,
                    input ready);
    modport sink   (input valid, input base, input exponent, input modulus,
                    output ready);
endinterface

### rtl/core/mexp_rsp_if.sv
// -----------------------------------------------------------------------------
// mexp_rsp_if
// Response channel: power_residue with valid/ready.
// -----------------------------------------------------------------------------
interface mexp_rsp_if import mexp_pkg::*;;
    logic   valid;
    logic   ready;
    field_t power_residue;

    modport source (output valid, output power_residue, input ready);
    modport sink   (input valid, input power_residue, output ready);
endinterface

### rtl/core/modular_exponentiation.sv
// -----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply modular exponentiation, bit-serial
// modular multiplier, one request in flight.
// -----------------------------------------------------------------------------
// Usage:
//   req : base, exponent, modulus. Taken when req.valid && req.ready; ready is
//         high only while the core is idle (no request in flight).
//   rsp : power_residue = base ** exponent mod modulus, one per request,
//         in request order. Held in an output register until rsp.ready.
// Steps: a base reduction, then for each exponent bit up to the highest set
// one a decision step, a multiply into the result if the bit is set and a
// squaring of the power; last the result loads the output register. The
// shared multiplier does the reduction, the multiplies and the squarings;
// it consumes one multiplier bit per cycle (one doubling and one conditional
// add, each mod modulus).
// Throughput: one request at a time; the next is taken once the core is back
// in idle, the cycle after the result moves to the output register.
// A modulus of zero skips the computation: the core goes straight to finish and answers zero.
// Reset clears the state machine and the output valid; datapath registers
// are not reset. If the receiver stalls, the finished result waits in the
// core until the output register frees; a new request is still taken while
// the previous response waits.
// -----------------------------------------------------------------------------
`include "modular_exponentiation_macros.svh"

module modular_exponentiation import mexp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    mexp_req_if.sink    req,
    mexp_rsp_if.source  rsp
);

    localparam cnt_t LAST_CNT = cnt_t'(DATA_WIDTH - 1);

    // (x + y) mod m for x, y < m
    function automatic word_t add_mod(word_t x, word_t y, word_t m);
        logic [DATA_WIDTH:0] sum;
        sum = {1'b0, x} + {1'b0, y};
        if (sum >= {1'b0, m})
        begin
            sum = sum - {1'b0, m};
        end
        return sum[DATA_WIDTH-1:0];
    endfunction

    state_t state_reg, state_next;
    word_t  m_reg,   m_next;      // modulus
    word_t  e_reg,   e_next;      // remaining exponent bits
    word_t  acc_reg, acc_next;    // running result
    word_t  pw_reg,  pw_next;     // current power of the base
    word_t  mx_reg,  mx_next;     // multiplicand
    word_t  my_reg,  my_next;     // multiplier, shifted out MSB first
    word_t  mp_reg,  mp_next;     // partial product
    cnt_t   cnt_reg, cnt_next;    // multiplier bit count
    field_t res_reg, res_next;
    logic   out_valid_reg, out_valid_next;

    logic   accept;
    logic   mul_last;
    logic   out_load;
    word_t  in_m;
    word_t  one_mod;
    word_t  dbl_mod;
    word_t  add_res;
    word_t  step_val;

    assign in_m    = req.modulus[DATA_WIDTH-1:0];
    assign one_mod = word_t'(in_m != word_t'(1));   // 1 mod m

    // One multiplier step: mp = 2*mp (+ mx if bit set), all mod m.
    assign dbl_mod  = add_mod(mp_reg, mp_reg, m_reg);
    assign add_res  = add_mod(dbl_mod, mx_reg, m_reg);
    assign step_val = my_reg[DATA_WIDTH-1] ? add_res : dbl_mod;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_m == '0) ? ST_FINISH : ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (mul_last)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (e_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else if (e_reg[0])
                begin
                    state_next = ST_MUL_ACC;
                end
                else
                begin
                    state_next = ST_MUL_PW;
                end
            end
            ST_MUL_ACC:
            begin
                if (mul_last)
                begin
                    state_next = ST_MUL_PW;
                end
            end
            ST_MUL_PW:
            begin
                if (mul_last)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        req.ready = (state_reg == ST_IDLE);
        accept    = req.valid && (state_reg == ST_IDLE);
        mul_last  = (cnt_reg == LAST_CNT);
        out_load  = (state_reg == ST_FINISH) && (!out_valid_reg || rsp.ready);
    end

    // Datapath
    always_comb
    begin
        m_next   = m_reg;
        e_next   = e_reg;
        acc_next = acc_reg;
        pw_next  = pw_reg;
        mx_next  = mx_reg;
        my_next  = my_reg;
        mp_next  = mp_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    m_next   = in_m;
                    e_next   = req.exponent[DATA_WIDTH-1:0];
                    acc_next = (in_m == '0) ? '0 : one_mod;
                    // base mod m computed as (1 mod m) * base
                    mx_next  = one_mod;
                    my_next  = req.base[DATA_WIDTH-1:0];
                    mp_next  = '0;
                    cnt_next = '0;
                end
            end
            ST_REDUCE:
            begin
                mp_next  = step_val;
                my_next  = my_reg << 1;
                cnt_next = cnt_reg + cnt_t'(1);
                if (mul_last)
                begin
                    pw_next = step_val;
                end
            end
            ST_NEXT:
            begin
                mp_next  = '0;
                cnt_next = '0;
                my_next  = pw_reg;
                mx_next  = e_reg[0] ? acc_reg : pw_reg;
            end
            ST_MUL_ACC:
            begin
                mp_next  = step_val;
                my_next  = my_reg << 1;
                cnt_next = cnt_reg + cnt_t'(1);
                if (mul_last)
                begin
                    // start squaring of the power
                    acc_next = step_val;
                    mx_next  = pw_reg;
                    my_next  = pw_reg;
                    mp_next  = '0;
                    cnt_next = '0;
                end
            end
            ST_MUL_PW:
            begin
                mp_next  = step_val;
                my_next  = my_reg << 1;
                cnt_next = cnt_reg + cnt_t'(1);
                if (mul_last)
                begin
                    pw_next = step_val;
                    e_next  = e_reg >> 1;
                end
            end
            ST_FINISH:
            begin
                cnt_next = cnt_reg;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            res_next       = field_t'(acc_reg);
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.power_residue = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg   <= m_next;
        e_reg   <= e_next;
        acc_reg <= acc_next;
        pw_reg  <= pw_next;
        mx_reg  <= mx_next;
        my_reg  <= my_next;
        mp_reg  <= mp_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

    // Multiplier operands stay reduced while it runs.
    `MEXP_ASSERT_NOW(a_mul_reduced, (state_reg == ST_REDUCE) || (state_reg == ST_MUL_ACC) || (state_reg == ST_MUL_PW), (mp_reg < m_reg) && (mx_reg < m_reg), "multiplier operand not below modulus")

    // Result and power are residues between exponent bits.
    `MEXP_ASSERT_NOW(a_loop_reduced, state_reg == ST_NEXT, (acc_reg < m_reg) && (pw_reg < m_reg), "running values not below modulus")

    // A finished result moves to the output and frees the core.
    `MEXP_ASSERT_NEXT(a_finish_loads, (state_reg == ST_FINISH) && (!out_valid_reg || rsp.ready), out_valid_reg && (state_reg == ST_IDLE), "finished result not loaded")

    // A response only ever comes from a finished computation.
    `MEXP_ASSERT_NOW(a_rsp_source, $rose(out_valid_reg), $past(state_reg == ST_FINISH), "response without finished computation")

endmodule
